// ----- rtl/ratpll_pkg.sv -----
// Package for the rotor angle tracking PLL: field widths, register map,
// microcode word layout and the microcode program itself.
// No dependencies; every other file in rtl/ imports this package.
package ratpll_pkg;

    // Item field widths.
    localparam int ANGLE_W = 16;
    localparam int DT_W    = 16;
    localparam int VOUT_W  = 32;

    // Internal state and datapath widths.
    localparam int EST_W   = 32;   // tracked angle, 2^-32 turn
    localparam int VEL_W   = 40;   // velocity, 2^-24 turn per second
    localparam int ED_W    = 48;   // error times time step
    localparam int OP_W    = 25;   // multiplier operand width (signed)
    localparam int PROD_W  = 49;   // signed product of two operands
    localparam int PART_W  = 24;   // split point of the wide operands
    localparam int ACC_W   = 73;   // accumulator for two partial products

    // Configuration register widths and reset values.
    localparam int GAIN_W = 24;
    localparam int ADV_W  = 16;
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 24'd51200;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 24'd512000;
    localparam logic [ADV_W-1:0]  ADV_TIME_RST   = 16'd524;

    // APB register map: register i sits at byte address 4*i.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int REGIDX_W = 2;
    localparam logic [REGIDX_W-1:0] REG_PROP_GAIN  = 2'd0;
    localparam logic [REGIDX_W-1:0] REG_INTEG_GAIN = 2'd1;
    localparam logic [REGIDX_W-1:0] REG_ADV_TIME   = 2'd2;

    // Program counter and named steps of the program.
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;
    localparam step_t STEP_WAIT  = 4'd0;
    localparam step_t STEP_STORE = 4'd4;
    localparam step_t STEP_VUPD  = 4'd8;
    localparam step_t STEP_AUPD  = 4'd12;
    localparam step_t STEP_OUT   = 4'd14;

    // Multiplier operand A: halves of error, error*dt and velocity.
    typedef enum logic [2:0] {
        MA_ERR_LO,
        MA_ERR_HI,
        MA_ED_LO,
        MA_ED_HI,
        MA_V_LO,
        MA_V_HI
    } mul_a_sel_t;

    // Multiplier operand B: time step or one of the registers.
    typedef enum logic [1:0] {
        MB_DT,
        MB_KI,
        MB_KP,
        MB_ADV
    } mul_b_sel_t;

    // Accumulator operation on the registered product.
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    // Sequencing: advance, wait for an input item, or jump once the
    // output register is free.
    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_WAIT_IN,
        SEQ_WAIT_OUT
    } seq_t;

    typedef struct packed {
        mul_a_sel_t a_sel;
        mul_b_sel_t b_sel;
        acc_op_t    acc_op;
        logic       wr_ed;
        logic       wr_vel;
        logic       wr_stepp;
        logic       wr_angle;
        logic       wr_out;
        seq_t       seq;
        step_t      target;
    } ucode_t;

    localparam ucode_t UC_NOP = '{
        a_sel:    MA_ERR_LO,
        b_sel:    MB_DT,
        acc_op:   ACC_HOLD,
        wr_ed:    1'b0,
        wr_vel:   1'b0,
        wr_stepp: 1'b0,
        wr_angle: 1'b0,
        wr_out:   1'b0,
        seq:      SEQ_NEXT,
        target:   STEP_WAIT
    };

    // The program. The product register sits between multiplier and
    // accumulator, so an accumulate falls in the step after its multiply.
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        w = UC_NOP;
        unique case (step)
            4'd0:
            begin
                w.seq = SEQ_WAIT_IN;
            end
            4'd1:
            begin
                w.a_sel = MA_ERR_LO; w.b_sel = MB_DT;
            end
            4'd2:
            begin
                w.a_sel = MA_ERR_HI; w.b_sel = MB_DT; w.acc_op = ACC_LOAD;
            end
            4'd3:
            begin
                w.acc_op = ACC_ADD;
            end
            4'd4:
            begin
                w.wr_ed = 1'b1;
            end
            4'd5:
            begin
                w.a_sel = MA_ED_LO; w.b_sel = MB_KI;
            end
            4'd6:
            begin
                w.a_sel = MA_ED_HI; w.b_sel = MB_KI; w.acc_op = ACC_LOAD;
            end
            4'd7:
            begin
                w.a_sel = MA_ED_LO; w.b_sel = MB_KP; w.acc_op = ACC_ADD;
            end
            4'd8:
            begin
                w.wr_vel = 1'b1;
                w.a_sel = MA_ED_HI; w.b_sel = MB_KP; w.acc_op = ACC_LOAD;
            end
            4'd9:
            begin
                w.a_sel = MA_V_LO; w.b_sel = MB_DT; w.acc_op = ACC_ADD;
            end
            4'd10:
            begin
                w.wr_stepp = 1'b1;
                w.a_sel = MA_V_HI; w.b_sel = MB_DT; w.acc_op = ACC_LOAD;
            end
            4'd11:
            begin
                w.a_sel = MA_V_LO; w.b_sel = MB_ADV; w.acc_op = ACC_ADD;
            end
            4'd12:
            begin
                w.wr_angle = 1'b1;
                w.a_sel = MA_V_HI; w.b_sel = MB_ADV; w.acc_op = ACC_LOAD;
            end
            4'd13:
            begin
                w.acc_op = ACC_ADD;
            end
            4'd14:
            begin
                w.wr_out = 1'b1;
                w.seq = SEQ_WAIT_OUT;
                w.target = STEP_WAIT;
            end
            default:
            begin
                w = UC_NOP;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/ratpll_if.sv -----
// Valid/ready channel interfaces for the rotor angle tracking PLL:
// one for input samples and one for result items.
// Depends on ratpll_pkg for the field widths.
interface ratpll_in_if
    import ratpll_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [ANGLE_W-1:0] measured_angle;
    logic [DT_W-1:0]    time_step;

    modport source (output valid, output measured_angle, output time_step, input ready);
    modport sink   (input valid, input measured_angle, input time_step, output ready);
endinterface

interface ratpll_out_if
    import ratpll_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [ANGLE_W-1:0]       tracked_angle;
    logic signed [VOUT_W-1:0] angular_velocity;
    logic [ANGLE_W-1:0]       advanced_angle;

    modport source (output valid, output tracked_angle, output angular_velocity,
                    output advanced_angle, input ready);
    modport sink   (input valid, input tracked_angle, input angular_velocity,
                    input advanced_angle, output ready);
endinterface

// ----- rtl/rotor_angle_tracking_pll.sv -----
// Top level of the rotor angle tracking PLL: APB register block, microcode
// sequencer, shared multiply-accumulate datapath and output register.
// Depends on ratpll_pkg and the channel interfaces in ratpll_if.sv.
//
//  Channel   | Direction | Handshake     | Payload
//  ----------+-----------+---------------+----------------------------------------
//  sample    | in        | valid/ready   | measured_angle, time_step
//  estimate  | out       | valid/ready   | tracked_angle, angular_velocity,
//            |           |               | advanced_angle
//  apb       | in        | psel/penable  | paddr, pwdata, prdata (pready tied 1)
//
// An item is accepted only while the program waits at its wait step, so a new
// item is not taken until the result of the last one has entered the output
// register. The single 25x25 multiplier forms ten partial products per item,
// one per step, with a product register in front of the accumulator.
// Reset clears the sequencer, the output valid flag, the loop state and loads
// the register defaults. A result not yet taken holds the program at its last
// step; the next item is still accepted while the previous result waits downstream.
module rotor_angle_tracking_pll
    import ratpll_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    ratpll_in_if.sink            sample,
    ratpll_out_if.source         estimate,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    // Register block.
    logic [GAIN_W-1:0] kp_reg, kp_next;
    logic [GAIN_W-1:0] ki_reg, ki_next;
    logic [ADV_W-1:0]  adv_reg, adv_next;
    logic              cfg_wr;
    logic [REGIDX_W-1:0] reg_idx;

    // Sequencer.
    step_t  step_reg, step_next;
    ucode_t uc;
    logic   in_fire;
    logic   out_free;

    // Datapath.
    logic [ANGLE_W-1:0]       meas_reg, meas_next;
    logic [DT_W-1:0]          dt_reg, dt_next;
    logic [EST_W-1:0]         angle_reg, angle_next;
    logic signed [VEL_W-1:0]  vel_reg, vel_next;
    logic signed [ED_W-1:0]   ed_reg, ed_next;
    logic [EST_W-1:0]         stepp_reg, stepp_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic [EST_W-1:0]         err;
    logic signed [OP_W-1:0]   mul_a;
    logic [GAIN_W-1:0]        mul_b_raw;
    logic signed [OP_W-1:0]   mul_b;
    logic signed [VEL_W:0]    vel_sum;

    // Output register.
    logic                     ovalid_reg, ovalid_next;
    logic [ANGLE_W-1:0]       otrack_reg, otrack_next;
    logic signed [VOUT_W-1:0] ovel_reg, ovel_next;
    logic [ANGLE_W-1:0]       oadv_reg, oadv_next;

    // APB access: writes complete in the access phase, reads are combinational.
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_comb
    begin
        kp_next  = kp_reg;
        ki_next  = ki_reg;
        adv_next = adv_reg;
        if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_PROP_GAIN:  kp_next  = pwdata[GAIN_W-1:0];
                REG_INTEG_GAIN: ki_next  = pwdata[GAIN_W-1:0];
                REG_ADV_TIME:   adv_next = pwdata[ADV_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_PROP_GAIN:  prdata = {{(PDATA_W-GAIN_W){1'b0}}, kp_reg};
            REG_INTEG_GAIN: prdata = {{(PDATA_W-GAIN_W){1'b0}}, ki_reg};
            REG_ADV_TIME:   prdata = {{(PDATA_W-ADV_W){1'b0}}, adv_reg};
            default:        prdata = '0;
        endcase
    end

    // Control word of the current step.
    assign uc       = ucode_rom(step_reg);
    assign in_fire  = sample.valid & sample.ready;
    assign out_free = ~ovalid_reg | estimate.ready;

    assign sample.ready = (uc.seq == SEQ_WAIT_IN);

    // Program counter with conditional holds and the return jump.
    always_comb
    begin
        unique case (uc.seq)
            SEQ_NEXT:     step_next = step_reg + 1'b1;
            SEQ_WAIT_IN:  step_next = sample.valid ? step_reg + 1'b1 : step_reg;
            SEQ_WAIT_OUT: step_next = out_free ? uc.target : step_reg;
            default:      step_next = STEP_WAIT;
        endcase
    end

    // Phase error in 2^-32 turn; wraps to a signed half turn by construction.
    assign err = {meas_reg, {(EST_W-ANGLE_W){1'b0}}} - angle_reg;

    // Operand selection: wide values are split into a signed upper part and
    // an unsigned lower part of PART_W bits.
    always_comb
    begin
        unique case (uc.a_sel)
            MA_ERR_LO: mul_a = {1'b0, err[PART_W-1:0]};
            MA_ERR_HI: mul_a = {{(OP_W-EST_W+PART_W){err[EST_W-1]}}, err[EST_W-1:PART_W]};
            MA_ED_LO:  mul_a = {1'b0, ed_reg[PART_W-1:0]};
            MA_ED_HI:  mul_a = {{(OP_W-ED_W+PART_W){ed_reg[ED_W-1]}}, ed_reg[ED_W-1:PART_W]};
            MA_V_LO:   mul_a = {1'b0, vel_reg[PART_W-1:0]};
            MA_V_HI:   mul_a = {{(OP_W-VEL_W+PART_W){vel_reg[VEL_W-1]}},
                                vel_reg[VEL_W-1:PART_W]};
            default:   mul_a = '0;
        endcase
    end

    always_comb
    begin
        unique case (uc.b_sel)
            MB_DT:   mul_b_raw = {{(GAIN_W-DT_W){1'b0}}, dt_reg};
            MB_KI:   mul_b_raw = ki_reg;
            MB_KP:   mul_b_raw = kp_reg;
            MB_ADV:  mul_b_raw = {{(GAIN_W-ADV_W){1'b0}}, adv_reg};
            default: mul_b_raw = '0;
        endcase
    end

    assign mul_b     = {1'b0, mul_b_raw};
    assign prod_next = PROD_W'(mul_a * mul_b);

    // Accumulator: load a low partial product or add a high one shifted up.
    always_comb
    begin
        unique case (uc.acc_op)
            ACC_HOLD: acc_next = acc_reg;
            ACC_LOAD: acc_next = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
            ACC_ADD:  acc_next = acc_reg + {prod_reg, {PART_W{1'b0}}};
            default:  acc_next = acc_reg;
        endcase
    end

    // Velocity update: add floor(ki*e*dt / 2^36) and saturate to 40 bits.
    assign vel_sum = {vel_reg[VEL_W-1], vel_reg}
                   + {{(VEL_W+1-(ACC_W-36)){acc_reg[ACC_W-1]}}, acc_reg[ACC_W-1:36]};

    always_comb
    begin
        meas_next  = meas_reg;
        dt_next    = dt_reg;
        ed_next    = ed_reg;
        stepp_next = stepp_reg;
        vel_next   = vel_reg;
        angle_next = angle_reg;

        if (in_fire)
        begin
            meas_next = sample.measured_angle;
            dt_next   = sample.time_step;
        end
        if (uc.wr_ed)
        begin
            ed_next = acc_reg[ED_W-1:0];
        end
        if (uc.wr_vel)
        begin
            priority if (vel_sum[VEL_W] & ~vel_sum[VEL_W-1])
                vel_next = {1'b1, {(VEL_W-1){1'b0}}};
            else if (~vel_sum[VEL_W] & vel_sum[VEL_W-1])
                vel_next = {1'b0, {(VEL_W-1){1'b1}}};
            else
                vel_next = vel_sum[VEL_W-1:0];
        end
        // Proportional step: floor(kp*e*dt / 2^28), kept modulo 2^32.
        if (uc.wr_stepp)
        begin
            stepp_next = acc_reg[28 +: EST_W];
        end
        // Angle step: floor(v*dt / 2^12) plus the proportional step.
        if (uc.wr_angle)
        begin
            angle_next = angle_reg + acc_reg[12 +: EST_W] + stepp_reg;
        end
    end

    // Output register: loaded at the last step, cleared when taken.
    always_comb
    begin
        ovalid_next = ovalid_reg;
        otrack_next = otrack_reg;
        ovel_next   = ovel_reg;
        oadv_next   = oadv_reg;
        if (uc.wr_out && out_free)
        begin
            ovalid_next = 1'b1;
            otrack_next = angle_reg[EST_W-1 -: ANGLE_W];
            ovel_next   = vel_reg[8 +: VOUT_W];
            oadv_next   = meas_reg + acc_reg[28 +: ANGLE_W];
        end
        else if (estimate.ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    assign estimate.valid            = ovalid_reg;
    assign estimate.tracked_angle    = otrack_reg;
    assign estimate.angular_velocity = ovel_reg;
    assign estimate.advanced_angle   = oadv_reg;

    // Control and loop state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg     <= PROP_GAIN_RST;
            ki_reg     <= INTEG_GAIN_RST;
            adv_reg    <= ADV_TIME_RST;
            step_reg   <= STEP_WAIT;
            ovalid_reg <= 1'b0;
            angle_reg  <= '0;
            vel_reg    <= '0;
        end
        else
        begin
            kp_reg     <= kp_next;
            ki_reg     <= ki_next;
            adv_reg    <= adv_next;
            step_reg   <= step_next;
            ovalid_reg <= ovalid_next;
            angle_reg  <= angle_next;
            vel_reg    <= vel_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        meas_reg   <= meas_next;
        dt_reg     <= dt_next;
        ed_reg     <= ed_next;
        stepp_reg  <= stepp_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        otrack_reg <= otrack_next;
        ovel_reg   <= ovel_next;
        oadv_reg   <= oadv_next;
    end

    // An accepted item always starts the program at its first working step.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> step_reg == STEP_WAIT + 1'b1)
        else $error("accepted item did not start the program");

    // A result appears only from the output step.
    a_out_from_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(step_reg) == STEP_OUT)
        else $error("result loaded outside the output step");

    // The velocity moves only in its update step.
    a_vel_update_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(vel_reg) |-> $past(step_reg) == STEP_VUPD)
        else $error("velocity changed outside its update step");

    // The tracked angle moves only in its update step.
    a_angle_update_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(angle_reg) |-> $past(step_reg) == STEP_AUPD)
        else $error("angle changed outside its update step");

    // No new item is taken while the program is away from its wait step.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg != STEP_WAIT |-> !in_fire)
        else $error("item accepted while the program was running");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for the rotor angle tracking PLL: drives angle samples, programs the
// loop gains over APB and checks every estimate against an in-bench loop model or a fixed expected value.
// Depends on ratpll_pkg, the channel interfaces in ratpll_if.sv and the RTL top.
module tb_top;
    import ratpll_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 7;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 160;
    localparam int DRAIN_SETTLE  = 4;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 300;
    localparam int RAIL_PHASE    = 3;

    // Register slot past the end of the map; writes to it must be ignored.
    localparam logic [REGIDX_W-1:0] REG_SPARE = 2'd3;
    localparam logic [GAIN_W-1:0]   GAIN_MAX  = '1;
    localparam logic [ADV_W-1:0]    ADV_MAX   = '1;
    localparam longint VEL_TOP    = (64'sd1 <<< 39) - 64'sd1;
    localparam longint VEL_BOTTOM = -(64'sd1 <<< 39);

    typedef struct packed {
        logic [ANGLE_W-1:0]       tracked;
        logic signed [VOUT_W-1:0] velocity;
        logic [ANGLE_W-1:0]       advanced;
    } estimate_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [DT_W-1:0]    dt;
        logic               known;
        estimate_t          want;
    } sample_row_t;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_PATTERN
    } sink_mode_t;

    // Directed samples. Rows marked known carry the estimate right after reset
    // with a zero time step: loop state untouched, advanced angle equals input.
    localparam sample_row_t DIRECTED [16] = '{
        '{16'hFFFF, 16'h0000, 1'b1, '{16'h0000, 32'sd0, 16'hFFFF}},
        '{16'h0000, 16'h0000, 1'b1, '{16'h0000, 32'sd0, 16'h0000}},
        '{16'h8000, 16'h0000, 1'b1, '{16'h0000, 32'sd0, 16'h8000}},
        '{16'h8000, 16'hFFFF, 1'b0, '0},
        '{16'h0000, 16'h0001, 1'b0, '0},
        '{16'hFFFF, 16'hFFFF, 1'b0, '0},
        '{16'h0000, 16'hFFFF, 1'b0, '0},
        '{16'h7FFF, 16'h8000, 1'b0, '0},
        '{16'h8001, 16'h0001, 1'b0, '0},
        '{16'h1234, 16'h0000, 1'b0, '0},
        '{16'hFFFF, 16'hFFFF, 1'b0, '0},
        '{16'hC000, 16'h4000, 1'b0, '0},
        '{16'h4000, 16'hFFFF, 1'b0, '0},
        '{16'h0001, 16'hFFFF, 1'b0, '0},
        '{16'hAAAA, 16'h5555, 1'b0, '0},
        '{16'h5555, 16'hAAAA, 1'b0, '0}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    ratpll_in_if  sample_ch ();
    ratpll_out_if estimate_ch ();

    // Loop model state and its copy of the registers.
    logic [EST_W-1:0]        angle_model;
    logic signed [VEL_W-1:0] vel_model;
    logic [GAIN_W-1:0]       kp_model;
    logic [GAIN_W-1:0]       ki_model;
    logic [ADV_W-1:0]        adv_model;

    estimate_t        pending_estimates [$];
    int               error_count   = 0;
    int               sent_items    = 0;
    int               hold_requests = 0;
    int               burst_left    = 0;
    bit               gaps_on       = 1'b1;
    logic [EST_W-1:0] rotor_pos     = '0;

    always #CLK_HALF clk = ~clk;

    rotor_angle_tracking_pll DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (sample_ch),
        .estimate (estimate_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // One loop update. Products are formed exactly at 96 bits and floored by
    // arithmetic shifts; angle terms wrap modulo one turn.
    function automatic estimate_t track_sample(input logic [ANGLE_W-1:0] angle,
                                               input logic [DT_W-1:0] dt);
        logic [EST_W-1:0]   diff;
        logic signed [95:0] err;
        logic signed [95:0] dt_w;
        logic signed [95:0] err_dt;
        logic signed [95:0] dv;
        logic signed [95:0] vel;
        logic signed [95:0] step;
        estimate_t          r;
        // An error of exactly half a turn lands on the negative side.
        diff   = {angle, 16'h0000} - angle_model;
        err    = {{64{diff[EST_W-1]}}, diff};
        dt_w   = {80'd0, dt};
        err_dt = err * dt_w;
        dv     = (err_dt * $signed({72'd0, ki_model})) >>> 36;
        vel    = {{56{vel_model[VEL_W-1]}}, vel_model} + dv;
        if (vel > VEL_TOP)
            vel = VEL_TOP;
        else if (vel < VEL_BOTTOM)
            vel = VEL_BOTTOM;
        vel_model = vel[VEL_W-1:0];
        // The fresh velocity feeds both the angle update and the outputs.
        step = ((vel * dt_w) >>> 12) + ((err_dt * $signed({72'd0, kp_model})) >>> 28);
        angle_model = angle_model + step[EST_W-1:0];
        step = (vel * $signed({80'd0, adv_model})) >>> 28;
        r.tracked  = angle_model[EST_W-1 -: ANGLE_W];
        r.velocity = vel_model[VEL_W-1 -: VOUT_W];
        r.advanced = angle + step[ANGLE_W-1:0];
        return r;
    endfunction

    // Offer one sample, record its estimate once taken, then maybe leave a gap.
    task automatic offer_sample(input logic [ANGLE_W-1:0] angle,
                                input logic [DT_W-1:0] dt,
                                input logic known, input estimate_t want);
        estimate_t predicted;
        sample_ch.valid          <= 1'b1;
        sample_ch.measured_angle <= angle;
        sample_ch.time_step      <= dt;
        do @(posedge clk); while (!sample_ch.ready);
        predicted = track_sample(angle, dt);
        pending_estimates.push_back(known ? want : predicted);
        sent_items++;
        if (gaps_on)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                burst_left = $urandom_range(0, 19);
                sample_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    endtask

    // Stop offering and wait until every estimate has come back.
    task automatic wait_for_drain();
        sample_ch.valid <= 1'b0;
        while (pending_estimates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SETTLE) @(posedge clk);
    endtask

    // Drive the error far to one side so the velocity runs into its rail.
    task automatic push_to_rail(input int len, input bit up);
        repeat (len)
            offer_sample(angle_model[EST_W-1 -: ANGLE_W] + (up ? 16'h7FFF : 16'h8001),
                         16'hFFFF - DT_W'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    // One APB transfer: setup phase, access phase, then back to idle.
    task automatic apb_access(input logic write, input logic [REGIDX_W-1:0] idx,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_register(input logic [REGIDX_W-1:0] idx,
                                  input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] unused;
        apb_access(1'b1, idx, value, unused);
        case (idx)
            REG_PROP_GAIN:  kp_model  = value[GAIN_W-1:0];
            REG_INTEG_GAIN: ki_model  = value[GAIN_W-1:0];
            REG_ADV_TIME:   adv_model = value[ADV_W-1:0];
            default: ;
        endcase
    endtask

    // Read every register back and compare with the model's copy.
    task automatic check_registers();
        logic [PDATA_W-1:0] kp_rd;
        logic [PDATA_W-1:0] ki_rd;
        logic [PDATA_W-1:0] adv_rd;
        apb_access(1'b0, REG_PROP_GAIN, '0, kp_rd);
        apb_access(1'b0, REG_INTEG_GAIN, '0, ki_rd);
        apb_access(1'b0, REG_ADV_TIME, '0, adv_rd);
        if (kp_rd[GAIN_W-1:0] !== kp_model)
        begin
            $display("%0t prop_gain readback: expected %h, actual %h",
                     $time, kp_model, kp_rd[GAIN_W-1:0]);
            error_count++;
        end
        if (ki_rd[GAIN_W-1:0] !== ki_model)
        begin
            $display("%0t integ_gain readback: expected %h, actual %h",
                     $time, ki_model, ki_rd[GAIN_W-1:0]);
            error_count++;
        end
        if (adv_rd[ADV_W-1:0] !== adv_model)
        begin
            $display("%0t advance_time readback: expected %h, actual %h",
                     $time, adv_model, adv_rd[ADV_W-1:0]);
            error_count++;
        end
    endtask

    // Stimulus: reset, directed samples, then phases of random traffic, each
    // phase under its own register setting.
    initial
    begin : stimulus
        int                 phase;
        int                 target;
        int                 pick;
        int                 len;
        int                 lim;
        longint             speed;
        logic [DT_W-1:0]    dt;
        logic [DT_W-1:0]    dt_base;
        logic [GAIN_W-1:0]  kp;
        logic [GAIN_W-1:0]  ki;
        logic [ADV_W-1:0]   adv;
        sample_ch.valid          <= 1'b0;
        sample_ch.measured_angle <= '0;
        sample_ch.time_step      <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        angle_model = '0;
        vel_model   = '0;
        kp_model    = PROP_GAIN_RST;
        ki_model    = INTEG_GAIN_RST;
        adv_model   = ADV_TIME_RST;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        check_registers();

        for (int i = 0; i < $size(DIRECTED); i++)
            offer_sample(DIRECTED[i].angle, DIRECTED[i].dt, DIRECTED[i].known,
                         DIRECTED[i].want);

        for (phase = 0; phase < PHASES; phase++)
        begin
            // New register setting, only with the loop idle.
            if (phase > 0)
            begin
                wait_for_drain();
                case (phase)
                    1:
                    begin
                        kp = '0; ki = '0; adv = '0;
                    end
                    2:
                    begin
                        kp = GAIN_MAX; ki = GAIN_MAX; adv = ADV_MAX;
                    end
                    RAIL_PHASE:
                    begin
                        kp = '0; ki = GAIN_MAX; adv = ADV_MAX;
                    end
                    4:
                    begin
                        kp = PROP_GAIN_RST; ki = INTEG_GAIN_RST; adv = ADV_TIME_RST;
                    end
                    default:
                    begin
                        kp  = $urandom_range(0, 1) ? GAIN_W'($urandom_range(0, 24'hFFFFFF))
                                                   : GAIN_W'($urandom_range(0, 1 << 18));
                        ki  = $urandom_range(0, 1) ? GAIN_W'($urandom_range(0, 24'hFFFFFF))
                                                   : GAIN_W'($urandom_range(0, 1 << 21));
                        adv = ADV_W'($urandom_range(0, 16'hFFFF));
                    end
                endcase
                write_register(REG_PROP_GAIN, PDATA_W'(kp));
                write_register(REG_INTEG_GAIN, PDATA_W'(ki));
                write_register(REG_ADV_TIME, PDATA_W'(adv));
                write_register(REG_SPARE, $urandom());
                check_registers();
            end
            gaps_on = ($urandom_range(0, 2) != 0);
            if (phase % 4 == 2)
                hold_requests <= hold_requests + 1;
            if (phase == RAIL_PHASE)
            begin
                push_to_rail(24, 1'b1);
                push_to_rail(48, 1'b0);
            end

            target = sent_items + PHASE_ITEMS;
            while (sent_items < target)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    // A rotor turning at constant speed, sampled with jitter.
                    len = $urandom_range(8, 40);
                    if ($urandom_range(0, 1))
                        rotor_pos = angle_model;
                    case ($urandom_range(0, 2))
                        0: lim = 1 << 16;
                        1: lim = 1 << 22;
                        default: lim = 1 << 27;
                    endcase
                    speed   = longint'($urandom_range(0, 2 * lim)) - longint'(lim);
                    dt_base = DT_W'($urandom_range(16, 4096));
                    repeat (len)
                    begin
                        dt = dt_base + DT_W'($urandom_range(0, 15));
                        rotor_pos = rotor_pos + EST_W'((speed * longint'(dt)) >>> 4);
                        offer_sample(rotor_pos[EST_W-1 -: ANGLE_W]
                                     + ANGLE_W'($urandom_range(0, 31)) - 16'd16,
                                     dt, 1'b0, '0);
                    end
                end
                else if (pick < 67)
                    push_to_rail($urandom_range(4, 20), $urandom_range(0, 1));
                else if (pick < 87)
                begin
                    repeat ($urandom_range(1, 10))
                        offer_sample(ANGLE_W'($urandom()), DT_W'($urandom()), 1'b0, '0);
                end
                else
                begin
                    // Corner samples: no elapsed time, error near half a turn,
                    // longest time step, angle at either end of the turn.
                    case ($urandom_range(0, 3))
                        0: offer_sample(ANGLE_W'($urandom()), '0, 1'b0, '0);
                        1: offer_sample(angle_model[EST_W-1 -: ANGLE_W] + 16'h8000,
                                        DT_W'($urandom()), 1'b0, '0);
                        2: offer_sample(ANGLE_W'($urandom()), 16'hFFFF, 1'b0, '0);
                        default: offer_sample($urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                                              DT_W'($urandom()), 1'b0, '0);
                    endcase
                end
            end
        end

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // Result side: check each estimate taken, then pick ready for the next
    // cycle from a changing stall pattern or a requested long hold-off.
    initial
    begin : result_sink
        sink_mode_t mode;
        int         mode_left;
        int         period;
        int         low_len;
        int         cyc;
        int         hold_left;
        int         holds_served;
        estimate_t  got;
        estimate_t  want;
        mode         = SINK_OPEN;
        mode_left    = 0;
        period       = 2;
        low_len      = 1;
        cyc          = 0;
        hold_left    = 0;
        holds_served = 0;
        estimate_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (estimate_ch.valid && estimate_ch.ready)
            begin
                got = '{estimate_ch.tracked_angle, estimate_ch.angular_velocity,
                        estimate_ch.advanced_angle};
                if (pending_estimates.size() == 0)
                begin
                    $display("%0t unexpected estimate: expected none, actual %h %h %h",
                             $time, got.tracked, got.velocity, got.advanced);
                    error_count++;
                end
                else
                begin
                    want = pending_estimates.pop_front();
                    if (got.tracked !== want.tracked)
                    begin
                        $display("%0t tracked_angle: expected %h, actual %h",
                                 $time, want.tracked, got.tracked);
                        error_count++;
                    end
                    if (got.velocity !== want.velocity)
                    begin
                        $display("%0t angular_velocity: expected %h, actual %h",
                                 $time, want.velocity, got.velocity);
                        error_count++;
                    end
                    if (got.advanced !== want.advanced)
                    begin
                        $display("%0t advanced_angle: expected %h, actual %h",
                                 $time, want.advanced, got.advanced);
                        error_count++;
                    end
                end
            end

            if (holds_served != hold_requests)
            begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0)
            begin
                mode      = sink_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(50, 400);
                period    = $urandom_range(2, 24);
                low_len   = $urandom_range(1, period - 1);
            end
            else
                mode_left--;

            if (hold_left > 0)
            begin
                hold_left--;
                estimate_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    SINK_OPEN:   estimate_ch.ready <= 1'b1;
                    SINK_RANDOM: estimate_ch.ready <= 1'($urandom_range(0, 1));
                    default:     estimate_ch.ready <= ((cyc % period) >= low_len);
                endcase
            end
        end
    end

    // Hard stop in case the loop hangs.
    initial
    begin : watchdog
        #4ms;
        $display("tb_top: errors");
        $finish;
    end

endmodule
